@@ hdl/pidaw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pidaw_pkg;

	// Field widths of the stream and configuration ports.
	localparam int SP_W     = 16;
	localparam int MEAS_W   = 12;
	localparam int KIND_W   = 2;
	localparam int DRIVE_W  = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 24;

	// Internal datapath widths.
	localparam int ERR_W    = 18;  // setpoint minus offset-corrected sample
	localparam int P_W      = 34;  // kp * error
	localparam int D_W      = 36;  // derivative gain * error delta
	localparam int SUM40_W  = 40;  // saturated integrator input
	localparam int INT_W    = 48;  // integrator, Q.24
	localparam int S_W      = 40;  // controller sum, Q.8
	localparam int OUT_W    = 24;  // clamped output, Q.8
	localparam int DIFF_W   = 41;  // clamped output minus sum
	localparam int MUL_A_W  = 21;
	localparam int MUL_B_W  = 25;
	localparam int MUL_P_W  = 46;
	localparam int WIDE_W   = 64;
	localparam int SPLIT    = 20;  // low part width of split operands

	// Fixed loop constants.
	localparam logic [15:0] DERIV_GAIN = 16'd0;
	localparam logic [15:0] RATE_LIMIT = 16'd0;
	localparam logic signed [S_W-1:0] RATE_STEP = {16'd0, RATE_LIMIT, 8'd0};

	// Register reset values.
	localparam logic [15:0] KP_RST       = 16'd512;
	localparam logic [23:0] KI_RST       = 24'd2097;
	localparam logic [15:0] KB_RST       = 16'd2048;
	localparam logic [15:0] DEADZONE_RST = 16'd5;
	localparam logic [15:0] OUT_MIN_RST  = 16'd720;
	localparam logic [15:0] OUT_MAX_RST  = 16'd13680;
	localparam logic [15:0] OUT_OFS_RST  = 16'd7200;
	localparam logic [11:0] IN_OFS_RST   = 12'd2048;

	// Saturation bounds.
	localparam logic signed [WIDE_W-1:0] SAT40_HI = (64'sd1 <<< 39) - 64'sd1;
	localparam logic signed [WIDE_W-1:0] SAT40_LO = -(64'sd1 <<< 39);
	localparam logic signed [WIDE_W-1:0] SAT48_HI = (64'sd1 <<< 47) - 64'sd1;
	localparam logic signed [WIDE_W-1:0] SAT48_LO = -(64'sd1 <<< 47);

	typedef enum logic [KIND_W-1:0] {
		KIND_STEP = 2'd0,
		KIND_ON   = 2'd1,
		KIND_OFF  = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP       = 3'd0,
		REG_KI       = 3'd1,
		REG_KB       = 3'd2,
		REG_DEADZONE = 3'd3,
		REG_OUT_MIN  = 3'd4,
		REG_OUT_MAX  = 3'd5,
		REG_OUT_OFS  = 3'd6,
		REG_IN_OFS   = 3'd7
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ERR,
		S_MP,
		S_MLO,
		S_MHI,
		S_INT,
		S_SUM,
		S_LIM,
		S_CLAMP,
		S_MWLO,
		S_MWHI,
		S_WIND,
		S_DONE
	} state_t;

	// Saturate a wide signed value to 40 bits.
	function automatic logic signed [SUM40_W-1:0] sat40(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] r;
		r = v;
		if (v > SAT40_HI) begin
			r = SAT40_HI;
		end else if (v < SAT40_LO) begin
			r = SAT40_LO;
		end
		return r[SUM40_W-1:0];
	endfunction

	// Saturate a wide signed value to 48 bits.
	function automatic logic signed [INT_W-1:0] sat48(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] r;
		r = v;
		if (v > SAT48_HI) begin
			r = SAT48_HI;
		end else if (v < SAT48_LO) begin
			r = SAT48_LO;
		end
		return r[INT_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ hdl/pid_antiwindup_controller_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Beat contents
// s_axis    in         tuser: kind; tdata: setpoint, measured
// m_axis    out        tdata: drive; tuser: clamped, running
// cfg       in         cfg_index selects the register, cfg_data is the value
//
// A running step passes the error, product, integrate, sum, limit, clamp, windup and done
// states; a stopped step skips from error to limit; turn-on, turn-off and kind 3 go from
// idle to limit, clamp and done. The next beat is taken only in idle. The shared 21x25
// multiplier gives five products per running step: P, two integral and two windup halves.
// Reset clears the run flag and all loop state and loads the default gains.
// A result that is not taken holds the block in its done state until the output frees up.

module pid_antiwindup_controller_unit
	import pidaw_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [31:0]          s_axis_tdata,   // [15:0] setpoint, [27:16] measured
	input  wire logic [KIND_W-1:0]    s_axis_tuser,   // [1:0] kind
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [DRIVE_W-1:0]        m_axis_tdata,   // [15:0] drive
	output logic [1:0]                m_axis_tuser,   // [0] clamped, [1] running
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data
);

	state_t state_q, state_d;

	// Configuration registers.
	logic [15:0] kp_q, kb_q, deadzone_q, out_min_q, out_max_q, out_ofs_q;
	logic [23:0] ki_q;
	logic [11:0] in_ofs_q;

	// Loop state.
	logic                       run_q;
	logic signed [INT_W-1:0]    integ_q;
	logic signed [SUM40_W-1:0]  windup_q;
	logic signed [ERR_W-1:0]    prev_err_q, cur_err_q;
	logic [OUT_W-1:0]           prev_out_q;

	// Working registers of one item.
	logic                       ctrl_q;
	logic signed [SP_W-1:0]     sp_q;
	logic [MEAS_W-1:0]          meas_q;
	logic signed [ERR_W-1:0]    e_q, edz_q;
	logic signed [SUM40_W-1:0]  sum_q;
	logic signed [MUL_P_W-1:0]  prod_q, acc_q;
	logic signed [P_W-1:0]      p_q;
	logic signed [D_W-1:0]      d_q;
	logic signed [S_W-1:0]      s_q;
	logic [OUT_W-1:0]           outq_q;
	logic                       hit_q;
	logic signed [DIFF_W-1:0]   diff_q;

	// Output register.
	logic                       m_valid_q;
	logic [DRIVE_W-1:0]         m_data_q;
	logic [1:0]                 m_user_q;

	logic in_beat, out_free, load_out;

	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;

	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	// Sequencer: next state and handshake outputs.
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		load_out      = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = (kind_t'(s_axis_tuser) == KIND_STEP) ? S_ERR : S_LIM;
				end
			end
			S_ERR:   state_d = run_q ? S_MP : S_LIM;
			S_MP:    state_d = S_MLO;
			S_MLO:   state_d = S_MHI;
			S_MHI:   state_d = S_INT;
			S_INT:   state_d = S_SUM;
			S_SUM:   state_d = S_LIM;
			S_LIM:   state_d = S_CLAMP;
			S_CLAMP: state_d = ctrl_q ? S_MWLO : S_DONE;
			S_MWLO:  state_d = S_MWHI;
			S_MWHI:  state_d = S_WIND;
			S_WIND:  state_d = S_DONE;
			S_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Error and deadzone, computed from the captured beat.
	logic signed [ERR_W-1:0] edz_c, e_c, dz_c;
	logic signed [WIDE_W-1:0] sum_wide_c;

	always_comb begin
		edz_c = {{(ERR_W-SP_W){sp_q[SP_W-1]}}, sp_q}
			- ({{(ERR_W-MEAS_W){1'b0}}, meas_q} - {{(ERR_W-MEAS_W){1'b0}}, in_ofs_q});
		dz_c  = {2'b00, deadzone_q};
		e_c   = edz_c;
		if ((deadzone_q != 16'd0) && (edz_c < dz_c) && (edz_c > -dz_c)) begin
			e_c = '0;
		end
		sum_wide_c = ({{(WIDE_W-ERR_W){e_c[ERR_W-1]}}, e_c} <<< 8)
			+ {{(WIDE_W-SUM40_W){windup_q[SUM40_W-1]}}, windup_q};
	end

	// Shared multiplier operand selection.
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MP: begin
				mul_a = {{(MUL_A_W-ERR_W){e_q[ERR_W-1]}}, e_q};
				mul_b = {9'd0, kp_q};
			end
			S_MLO: begin
				mul_a = {1'b0, sum_q[SPLIT-1:0]};
				mul_b = {1'b0, ki_q};
			end
			S_MHI: begin
				mul_a = {sum_q[SUM40_W-1], sum_q[SUM40_W-1:SPLIT]};
				mul_b = {1'b0, ki_q};
			end
			S_MWLO: begin
				mul_a = {1'b0, diff_q[SPLIT-1:0]};
				mul_b = {9'd0, kb_q};
			end
			S_MWHI: begin
				mul_a = diff_q[DIFF_W-1:SPLIT];
				mul_b = {9'd0, kb_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Recombine the two halves of a split product and drop 8 fraction bits.
	logic signed [WIDE_W-1:0] prod_full_c, prod_shr_c, integ_sum_c;
	logic signed [INT_W-1:0]  integ_base_c;

	always_comb begin
		prod_full_c  = ({{(WIDE_W-MUL_P_W){prod_q[MUL_P_W-1]}}, prod_q} <<< SPLIT)
			+ {{(WIDE_W-MUL_P_W){acc_q[MUL_P_W-1]}}, acc_q};
		prod_shr_c   = prod_full_c >>> 8;
		integ_base_c = (sp_q == '0) ? '0 : integ_q;
		integ_sum_c  = {{(WIDE_W-INT_W){integ_base_c[INT_W-1]}}, integ_base_c} + prod_shr_c;
	end

	// Derivative term from the registered raw error.
	logic signed [ERR_W:0]   ediff_c;
	logic signed [D_W-1:0]   d_c;

	always_comb begin
		ediff_c = {edz_q[ERR_W-1], edz_q} - {prev_err_q[ERR_W-1], prev_err_q};
		d_c     = $signed({1'b0, DERIV_GAIN}) * ediff_c;
	end

	// Controller sum, rate limit, offset and clamp.
	logic signed [S_W-1:0] s_sum_c, s_lim_c, prev_ext_c, delta_c, ofs_ext_c;
	logic signed [S_W-1:0] lo_c, hi_c;
	logic [OUT_W-1:0]      outq_c;
	logic                  hit_c;

	always_comb begin
		s_sum_c = {{(S_W-P_W){p_q[P_W-1]}}, p_q}
			+ {{(S_W-(INT_W-16)){integ_q[INT_W-1]}}, integ_q[INT_W-1:16]}
			+ {{(S_W-D_W){d_q[D_W-1]}}, d_q};

		prev_ext_c = {{(S_W-OUT_W){1'b0}}, prev_out_q};
		delta_c    = s_q - prev_ext_c;
		s_lim_c    = s_q;
		if (ctrl_q && run_q && (RATE_LIMIT != 16'd0)) begin
			if (delta_c > RATE_STEP) begin
				s_lim_c = prev_ext_c + RATE_STEP;
			end else if (delta_c < -RATE_STEP) begin
				s_lim_c = prev_ext_c - RATE_STEP;
			end
		end
		ofs_ext_c = {16'd0, out_ofs_q, 8'd0};

		lo_c   = {16'd0, out_min_q, 8'd0};
		hi_c   = {16'd0, out_max_q, 8'd0};
		outq_c = s_q[OUT_W-1:0];
		hit_c  = 1'b1;
		if (s_q < lo_c) begin
			outq_c = lo_c[OUT_W-1:0];
		end else if (s_q > hi_c) begin
			outq_c = hi_c[OUT_W-1:0];
		end else begin
			hit_c = 1'b0;
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q       <= KP_RST;
			ki_q       <= KI_RST;
			kb_q       <= KB_RST;
			deadzone_q <= DEADZONE_RST;
			out_min_q  <= OUT_MIN_RST;
			out_max_q  <= OUT_MAX_RST;
			out_ofs_q  <= OUT_OFS_RST;
			in_ofs_q   <= IN_OFS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_KP:       kp_q       <= cfg_data[15:0];
				REG_KI:       ki_q       <= cfg_data;
				REG_KB:       kb_q       <= cfg_data[15:0];
				REG_DEADZONE: deadzone_q <= cfg_data[15:0];
				REG_OUT_MIN:  out_min_q  <= cfg_data[15:0];
				REG_OUT_MAX:  out_max_q  <= cfg_data[15:0];
				REG_OUT_OFS:  out_ofs_q  <= cfg_data[15:0];
				REG_IN_OFS:   in_ofs_q   <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// Loop state: run flag, integrator, windup and history.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= 1'b0;
			integ_q    <= '0;
			windup_q   <= '0;
			prev_err_q <= '0;
			cur_err_q  <= '0;
			prev_out_q <= '0;
			ctrl_q     <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						ctrl_q <= (kind_t'(s_axis_tuser) == KIND_STEP);
						case (kind_t'(s_axis_tuser))
							KIND_ON: run_q <= 1'b1;
							KIND_OFF: begin
								run_q      <= 1'b0;
								integ_q    <= '0;
								windup_q   <= '0;
								prev_err_q <= '0;
								cur_err_q  <= '0;
								prev_out_q <= '0;
							end
							default: ;
						endcase
					end
				end
				S_ERR: begin
					if (run_q) begin
						cur_err_q <= edz_c;
					end
				end
				S_INT: begin
					integ_q <= (ki_q == '0) ? '0 : sat48(integ_sum_c);
				end
				S_WIND: begin
					windup_q   <= sat40(prod_shr_c);
					prev_err_q <= cur_err_q;
					prev_out_q <= outq_q;
				end
				default: ;
			endcase
		end
	end

	// Datapath working registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		case (state_q)
			S_IDLE: begin
				if (in_beat) begin
					sp_q   <= s_axis_tdata[15:0];
					meas_q <= s_axis_tdata[27:16];
					s_q    <= '0;
				end
			end
			S_ERR: begin
				edz_q <= edz_c;
				e_q   <= e_c;
				sum_q <= sat40(sum_wide_c);
			end
			S_MP:    d_q    <= d_c;
			S_MLO:   p_q    <= prod_q[P_W-1:0];
			S_MHI:   acc_q  <= prod_q;
			S_SUM:   s_q    <= s_sum_c;
			S_LIM:   s_q    <= s_lim_c + ofs_ext_c;
			S_CLAMP: begin
				outq_q <= outq_c;
				hit_q  <= hit_c;
				diff_q <= {{(DIFF_W-OUT_W){1'b0}}, outq_c} - {s_q[S_W-1], s_q};
			end
			S_MWHI:  acc_q  <= prod_q;
			default: ;
		endcase
	end

	// Output register: holds the result beat until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_data_q <= outq_q[OUT_W-1:8];
			m_user_q <= {run_q, hit_q};
		end
	end

`ifndef SYNTHESIS
	// A stopped loop never carries integrator charge.
	assert property (@(posedge clk) disable iff (!arst_n)
		!run_q |-> (integ_q == '0))
		else $error("integrator nonzero while stopped");

	// An unclamped result lies inside the output window.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLAMP) |=> (hit_q ||
			((outq_q >= {$past(out_min_q), 8'd0}) && (outq_q <= {$past(out_max_q), 8'd0}))))
		else $error("unclamped output outside window");

	// A finished result waits while the output register is still full.
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DONE) && m_valid_q && !m_axis_tready) |=> (state_q == S_DONE))
		else $error("result overwrote a pending output beat");
`endif

endmodule

`default_nettype wire
